// ===== hw/rtl/ofgc_pkg.sv =====
// ofgc_pkg: shared types and constants for the optical flow gyro compensation block
// word layouts, ring geometry, register indexes and fixed-point constants
// no dependencies
package ofgc_pkg;

  // ring geometry
  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // fixed-point constants
  localparam logic signed [15:0] RATE_LIMIT  = 16'sd3200;     // 200 dps in 1/16 dps
  localparam logic signed [23:0] DEG2RAD_Q16 = 24'sd4685083;  // 4096*pi/180 in Q16
  localparam logic        [32:0] ERR_INIT    = 33'h0_7FFF_FFFF;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_COS_ROT   = 2'd0,
    REG_SIN_ROT   = 2'd1,
    REG_FLIP_X    = 2'd2,
    REG_GYRO_DLY  = 2'd3
  } reg_idx_e;

  // input word
  typedef struct packed {
    logic signed [31:0] flow_x;
    logic signed [31:0] flow_y;
    logic        [31:0] stamp_us;
    logic signed [15:0] gyro_roll;
    logic signed [15:0] gyro_y_rate;
    logic        [7:0]  link_quality;
  } in_word_t;

  // output word
  typedef struct packed {
    logic               new_data;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic               ok_x;
    logic               ok_y;
    logic signed [31:0] last_raw_x;
    logic signed [31:0] last_raw_y;
    logic        [7:0]  quality_out;
  } out_word_t;

  // one ring slot
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic        [31:0] stamp;
  } ring_entry_t;

endpackage

// ===== hw/rtl/optical_flow_gyro_compensation.sv =====
// optical_flow_gyro_compensation: flow rotation, gyro ring match and rate subtraction
// holds the gyro ring memory, the shared multiplier and the item sequencer
// depends on ofgc_pkg
//
// One input word carries a flow sample, its timestamp, the gyro roll and Y
// rates and a quality byte; one output word follows for every input word. A
// word whose timestamp equals the last processed one only refreshes the
// quality byte: it goes from S_IDLE straight to S_OUT, which loads the output
// register, and the block returns to S_IDLE to take the next word. A new
// sample passes through rotation on the shared 32x24 multiplier, a ring scan
// (one slot read per cycle through the single read port of the ring memory,
// then the last compare), rate conversion and subtraction on the same
// multiplier, the load of the output register and S_IDLE to take the next
// word. One word is in work at a time; the next is taken once the previous
// result has been placed in the output register, so a full output register
// that is stalled holds the block in S_OUT. Ring slots are marked filled by
// per-slot flags that reset clears, so no clearing pass follows reset.
// Configuration is through the APB port at byte addresses 0, 4, 8 and 12.
module optical_flow_gyro_compensation (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ofgc_pkg::in_word_t  in_word_i,
  // output words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ofgc_pkg::out_word_t out_word_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ofgc_pkg::*;

  localparam int unsigned ACC_W = 50;  // rotation sums
  localparam int unsigned ROT_W = 36;  // rotated flow
  localparam int unsigned GP_W  = 40;  // gyro products
  localparam int unsigned GC_W  = 24;  // converted gyro rate
  localparam int unsigned DIF_W = 37;  // difference before saturation

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROT  = 5'b00010,
    S_SCAN = 5'b00100,
    S_GYRO = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  // rounding of a rotation sum by 14 bits, ties away from zero, optional negation
  function automatic logic signed [ROT_W-1:0] rnd14(input logic signed [ACC_W-1:0] v,
                                                    input logic flip);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] sum;
    logic [ROT_W-1:0] r;
    mag = v[ACC_W-1] ? (~v + ACC_W'(1)) : v;
    sum = mag + (ACC_W'(1) << 13);
    r   = sum[14 +: ROT_W];
    return (v[ACC_W-1] ^ flip) ? signed'(~r + ROT_W'(1)) : signed'(r);
  endfunction

  // rounding of a gyro product by 16 bits, ties away from zero
  function automatic logic signed [GC_W-1:0] rnd16(input logic signed [GP_W-1:0] v);
    logic [GP_W-1:0] mag;
    logic [GP_W-1:0] sum;
    logic [GC_W-1:0] r;
    mag = v[GP_W-1] ? (~v + GP_W'(1)) : v;
    sum = mag + (GP_W'(1) << 15);
    r   = sum[16 +: GC_W];
    return v[GP_W-1] ? signed'(~r + GC_W'(1)) : signed'(r);
  endfunction

  // difference saturated to 32 bits
  function automatic logic signed [31:0] sub_sat(input logic signed [ROT_W-1:0] a,
                                                 input logic signed [GC_W-1:0] b);
    logic signed [DIF_W-1:0] d;
    d = DIF_W'(a) - DIF_W'(b);
    if (d > DIF_W'(32'sh7FFF_FFFF)) begin
      return 32'sh7FFF_FFFF;
    end else if (d < -DIF_W'(33'sh0_8000_0000)) begin
      return 32'sh8000_0000;
    end else begin
      return d[31:0];
    end
  endfunction

  // configuration registers
  logic signed [15:0] cos_q, sin_q;
  logic               flip_q;
  logic        [19:0] delay_q;

  // sequencer and held state
  state_e             state_q, state_d;
  logic        [2:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic [RING_DEPTH-1:0] filled_q, filled_d;
  logic        [31:0] last_stamp_q, last_stamp_d;
  logic signed [31:0] held_x_q, held_x_d, held_y_q, held_y_d;
  logic signed [31:0] raw_x_q, raw_x_d, raw_y_q, raw_y_d;
  logic               ok_x_q, ok_x_d, ok_y_q, ok_y_d;
  logic               new_q, new_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q, out_word_d;

  // scan control
  logic [IDX_W:0]     issue_q, issue_d;
  logic [IDX_W-1:0]   rd_slot_q, rd_slot_d;
  logic               rd_vld_q, rd_vld_d;
  logic        [32:0] best_q, best_d;
  logic signed [15:0] sel_roll_q, sel_roll_d, sel_pitch_q, sel_pitch_d;

  // datapath payload
  in_word_t           item_q, item_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [55:0] prod_q;
  logic signed [ROT_W-1:0] rx_q, rx_d, ry_q, ry_d;
  logic signed [GC_W-1:0]  gc_q, gc_d;

  // ring memory
  ring_entry_t        ring_mem [RING_DEPTH];
  ring_entry_t        rd_data_q;
  ring_entry_t        wr_data;
  logic               wr_en, rd_en;
  logic [IDX_W-1:0]   rd_addr;

  // combinational helpers
  logic signed [31:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [15:0] pitch;
  logic               ok_x, ok_y;
  logic signed [31:0] age;
  logic signed [32:0] err;
  logic        [32:0] err_abs;
  logic               cfg_wr;
  logic [IDX_W-1:0]   pos_next;

  // apb port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_COS_ROT:  prdata = 32'(cos_q);
      REG_SIN_ROT:  prdata = 32'(sin_q);
      REG_FLIP_X:   prdata = {31'd0, flip_q};
      REG_GYRO_DLY: prdata = {12'd0, delay_q};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= 16'sd16384;
      sin_q   <= 16'sd0;
      flip_q  <= 1'b0;
      delay_q <= 20'd0;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_COS_ROT:  cos_q   <= pwdata[15:0];
        REG_SIN_ROT:  sin_q   <= pwdata[15:0];
        REG_FLIP_X:   flip_q  <= pwdata[0];
        REG_GYRO_DLY: delay_q <= pwdata[19:0];
        default:      ;
      endcase
    end
  end

  // handshake outputs
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // pitch from the Y rate, negation saturated
  assign pitch = (item_q.gyro_y_rate == 16'sh8000) ? 16'sh7FFF : -item_q.gyro_y_rate;

  // rate limits on the matched slot
  assign ok_x = (sel_roll_q  <= RATE_LIMIT) && (sel_roll_q  >= -RATE_LIMIT);
  assign ok_y = (sel_pitch_q <= RATE_LIMIT) && (sel_pitch_q >= -RATE_LIMIT);

  // age error of the slot being compared
  assign age     = signed'(item_q.stamp_us - rd_data_q.stamp);
  assign err     = 33'(age) - signed'({13'd0, delay_q});
  assign err_abs = err[32] ? unsigned'(-err) : unsigned'(err);

  assign pos_next = (pos_q == IDX_W'(RING_DEPTH - 1)) ? '0 : pos_q + IDX_W'(1);

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_ROT) begin
      unique case (cnt_q)
        3'd0:    begin mul_a = item_q.flow_x; mul_b = 24'(cos_q); end
        3'd1:    begin mul_a = item_q.flow_y; mul_b = 24'(sin_q); end
        3'd2:    begin mul_a = item_q.flow_x; mul_b = 24'(sin_q); end
        3'd3:    begin mul_a = item_q.flow_y; mul_b = 24'(cos_q); end
        default: ;
      endcase
    end else if (state_q == S_GYRO) begin
      unique case (cnt_q)
        3'd0:    begin mul_a = 32'(sel_roll_q);  mul_b = DEG2RAD_Q16; end
        3'd1:    begin mul_a = 32'(sel_pitch_q); mul_b = DEG2RAD_Q16; end
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    filled_d     = filled_q;
    last_stamp_d = last_stamp_q;
    held_x_d     = held_x_q;
    held_y_d     = held_y_q;
    raw_x_d      = raw_x_q;
    raw_y_d      = raw_y_q;
    ok_x_d       = ok_x_q;
    ok_y_d       = ok_y_q;
    new_d        = new_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_word_d   = out_word_q;
    issue_d      = issue_q;
    rd_slot_d    = rd_slot_q;
    rd_vld_d     = 1'b0;
    best_d       = best_q;
    sel_roll_d   = sel_roll_q;
    sel_pitch_d  = sel_pitch_q;
    item_d       = item_q;
    acc_d        = acc_q;
    rx_d         = rx_q;
    ry_d         = ry_q;
    gc_d         = gc_q;
    wr_en        = 1'b0;
    wr_data      = '{roll: item_q.gyro_roll, pitch: pitch, stamp: item_q.stamp_us};
    rd_en        = 1'b0;
    rd_addr      = issue_q[IDX_W-1:0];

    unique case (state_q)
      // take a word; a repeated stamp goes straight to output
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_word_i;
          cnt_d  = 3'd0;
          if (in_word_i.stamp_us == last_stamp_q) begin
            new_d   = 1'b0;
            state_d = S_OUT;
          end else begin
            state_d = S_ROT;
          end
        end
      end

      // rotation on the shared multiplier, then ring write
      S_ROT: begin
        cnt_d = cnt_q + 3'd1;
        unique case (cnt_q)
          3'd1: acc_d = prod_q[ACC_W-1:0];
          3'd2: acc_d = acc_q - prod_q[ACC_W-1:0];
          3'd3: begin
            rx_d  = rnd14(acc_q, flip_q);
            acc_d = prod_q[ACC_W-1:0];
          end
          3'd4: acc_d = acc_q + prod_q[ACC_W-1:0];
          3'd5: begin
            ry_d            = rnd14(acc_q, 1'b0);
            pos_d           = pos_next;
            wr_en           = 1'b1;
            filled_d[pos_next] = 1'b1;
            best_d          = ERR_INIT;
            sel_roll_d      = item_q.gyro_roll;
            sel_pitch_d     = pitch;
            issue_d         = '0;
            state_d         = S_SCAN;
          end
          default: ;
        endcase
      end

      // one slot read per cycle, compare on the returned data
      S_SCAN: begin
        if (issue_q < (IDX_W+1)'(RING_DEPTH)) begin
          rd_en     = 1'b1;
          rd_vld_d  = 1'b1;
          rd_slot_d = issue_q[IDX_W-1:0];
          issue_d   = issue_q + (IDX_W+1)'(1);
        end
        if (rd_vld_q) begin
          if (filled_q[rd_slot_q] && (err_abs < best_q)) begin
            best_d      = err_abs;
            sel_roll_d  = rd_data_q.roll;
            sel_pitch_d = rd_data_q.pitch;
          end
          if (rd_slot_q == IDX_W'(RING_DEPTH - 1)) begin
            cnt_d   = 3'd0;
            state_d = S_GYRO;
          end
        end
      end

      // rate conversion and subtraction
      S_GYRO: begin
        cnt_d = cnt_q + 3'd1;
        unique case (cnt_q)
          3'd1: gc_d = rnd16(prod_q[GP_W-1:0]);
          3'd2: begin
            if (ok_x) held_x_d = sub_sat(rx_q, gc_q);
            gc_d = rnd16(prod_q[GP_W-1:0]);
          end
          3'd3: begin
            if (ok_y) held_y_d = sub_sat(ry_q, gc_q);
            ok_x_d       = ok_x;
            ok_y_d       = ok_y;
            raw_x_d      = item_q.flow_x;
            raw_y_d      = item_q.flow_y;
            last_stamp_d = item_q.stamp_us;
            new_d        = 1'b1;
            state_d      = S_OUT;
          end
          default: ;
        endcase
      end

      // load the output register once it is free
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_word_d  = '{new_data:    new_q,
                          comp_x:      held_x_q,
                          comp_y:      held_y_q,
                          ok_x:        ok_x_q,
                          ok_y:        ok_y_q,
                          last_raw_x:  raw_x_q,
                          last_raw_y:  raw_y_q,
                          quality_out: item_q.link_quality};
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control and held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= 3'd0;
      pos_q        <= '0;
      filled_q     <= '0;
      last_stamp_q <= 32'd0;
      held_x_q     <= 32'sd0;
      held_y_q     <= 32'sd0;
      raw_x_q      <= 32'sd0;
      raw_y_q      <= 32'sd0;
      ok_x_q       <= 1'b1;
      ok_y_q       <= 1'b1;
      new_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      issue_q      <= '0;
      rd_slot_q    <= '0;
      rd_vld_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      pos_q        <= pos_d;
      filled_q     <= filled_d;
      last_stamp_q <= last_stamp_d;
      held_x_q     <= held_x_d;
      held_y_q     <= held_y_d;
      raw_x_q      <= raw_x_d;
      raw_y_q      <= raw_y_d;
      ok_x_q       <= ok_x_d;
      ok_y_q       <= ok_y_d;
      new_q        <= new_d;
      out_valid_q  <= out_valid_d;
      issue_q      <= issue_d;
      rd_slot_q    <= rd_slot_d;
      rd_vld_q     <= rd_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    acc_q       <= acc_d;
    prod_q      <= 56'(mul_a) * 56'(mul_b);
    rx_q        <= rx_d;
    ry_q        <= ry_d;
    gc_q        <= gc_d;
    best_q      <= best_d;
    sel_roll_q  <= sel_roll_d;
    sel_pitch_q <= sel_pitch_d;
    out_word_q  <= out_word_d;
  end

  // gyro ring memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[pos_d] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

endmodule

// ===== test/optical_flow_gyro_compensation_tb.sv =====
// optical_flow_gyro_compensation_tb: self-checking bench for the flow gyro compensation block
// directed table then random words over several register settings, checked by a local model or typed-in results
// depends on ofgc_pkg and optical_flow_gyro_compensation
module optical_flow_gyro_compensation_tb;
  import ofgc_pkg::*;

  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_WORDS   = 180;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned DIR_N         = 19;

  // one row of the directed table: input word, whether the result is typed in, the result
  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t exp;
  } dir_row_t;

  localparam out_word_t NO_EXP = '0;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // stamp zero straight after reset counts as a repeat
    {32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 8'hA5, 1'b1,
     {1'b0, 32'h0, 32'h0, 1'b1, 1'b1, 32'h0, 32'h0, 8'hA5}},
    // flow extremes, no gyro, identity rotation
    {32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 16'h0, 16'h0, 8'h5A, 1'b1,
     {1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 8'h5A}},
    // repeated stamp only refreshes the quality byte
    {32'd1234, 32'd5678, 32'd1, 16'h0, 16'h0, 8'hFF, 1'b1,
     {1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 8'hFF}},
    // rates on and just past the 200 dps limit
    {32'd1000, -32'sd1000, 32'd2, 16'sd3200, -16'sd3200, 8'h00, 1'b0, NO_EXP},
    {32'd65536, 32'd65536, 32'd3, 16'sd3201, 16'sd3200, 8'h01, 1'b0, NO_EXP},
    {-32'sd65536, 32'd12345, 32'd4, -16'sd3201, -16'sd3201, 8'h02, 1'b0, NO_EXP},
    // gyro extremes, pitch negation saturates
    {32'h5555_5555, 32'hAAAA_AAAA, 32'd5, 16'h8000, 16'h8000, 8'h80, 1'b0, NO_EXP},
    {32'hAAAA_AAAA, 32'h5555_5555, 32'd6, 16'h7FFF, 16'h7FFF, 8'h7F, 1'b0, NO_EXP},
    // difference saturates high on x and low on y
    {32'h7FFF_FFFF, 32'h8000_0000, 32'd7, -16'sd3200, -16'sd3200, 8'h10, 1'b0, NO_EXP},
    // stamp wrap, then zero as an ordinary stamp
    {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'sd100, -16'sd100, 8'h20, 1'b0, NO_EXP},
    {32'd1, -32'sd1, 32'h0, 16'sd1, -16'sd1, 8'h21, 1'b0, NO_EXP},
    // same stamp in two slots: lowest slot wins the tie
    {32'd100, 32'd200, 32'd10, 16'sd111, 16'sd222, 8'h22, 1'b0, NO_EXP},
    {32'd300, 32'd400, 32'd20, 16'sd333, 16'sd444, 8'h23, 1'b0, NO_EXP},
    {32'd500, 32'd600, 32'd10, 16'sd555, 16'sd666, 8'h24, 1'b0, NO_EXP},
    // far stamps give ages of both signs near the 32 bit edge
    {32'd7000, -32'sd7000, 32'h8000_0000, 16'sd777, -16'sd777, 8'h25, 1'b0, NO_EXP},
    {-32'sd9, 32'd9, 32'h7FFF_FFFF, -16'sd999, 16'sd999, 8'h26, 1'b0, NO_EXP},
    {32'h0, 32'h0, 32'h7FFF_FFFF, 16'h0, 16'h0, 8'h27, 1'b0, NO_EXP},
    // small values around the rounding point
    {-32'sd1, 32'd1, 32'd100, 16'sd1, 16'sd1, 8'h28, 1'b0, NO_EXP},
    {32'd3, -32'sd3, 32'd101, -16'sd7, 16'sd7, 8'h29, 1'b0, NO_EXP}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        calm = 1'b0;
  int unsigned fails = 0;
  int unsigned cycle_cnt = 0;
  out_word_t   comp_words_q [$];

  // model copy of the registers
  longint cfg_cos   = 16384;
  longint cfg_sin   = 0;
  logic   cfg_flip  = 1'b0;
  longint cfg_delay = 0;

  // model copy of the block state
  logic [31:0] last_stamp;
  longint      held_x, held_y, held_raw_x, held_raw_y;
  logic        held_okx, held_oky;
  int unsigned ring_pos;
  longint      ring_roll  [RING_DEPTH];
  longint      ring_pitch [RING_DEPTH];
  logic [31:0] ring_stamp [RING_DEPTH];
  bit          ring_full  [RING_DEPTH];

  optical_flow_gyro_compensation i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // shift right with rounding to nearest, ties away from zero
  function automatic longint rnd_shift(longint v, int unsigned sh);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // compensated output word for one accepted input word, advancing the model state
  function automatic out_word_t compensated_word(in_word_t w);
    longint      fx, fy, rx, ry, pitch, gx, gy, age, err, best;
    logic [31:0] d;
    int unsigned sel;
    int          i;
    logic        okx, oky;
    out_word_t   o;
    fx = longint'($signed(w.flow_x));
    fy = longint'($signed(w.flow_y));
    o.new_data = 1'b0;
    if (w.stamp_us != last_stamp) begin
      // mounting rotation and optional flip
      rx = rnd_shift(fx * cfg_cos - fy * cfg_sin, 14);
      ry = rnd_shift(fx * cfg_sin + fy * cfg_cos, 14);
      if (cfg_flip) rx = -rx;
      // push the gyro pair, y rate negated into pitch
      pitch = -longint'($signed(w.gyro_y_rate));
      if (pitch > 32767) pitch = 32767;
      ring_pos = (ring_pos + 1) % RING_DEPTH;
      ring_roll[ring_pos]  = longint'($signed(w.gyro_roll));
      ring_pitch[ring_pos] = pitch;
      ring_stamp[ring_pos] = w.stamp_us;
      ring_full[ring_pos]  = 1'b1;
      // filled slot with age nearest the delay, first minimum wins
      sel  = ring_pos;
      best = 64'sd2147483647;
      for (i = 0; i < RING_DEPTH; i++) begin
        if (ring_full[i]) begin
          d   = w.stamp_us - ring_stamp[i];
          age = longint'($signed(d));
          err = age - cfg_delay;
          if (err < 0) err = -err;
          if (err < best) begin
            best = err;
            sel  = i;
          end
        end
      end
      gx  = ring_roll[sel];
      gy  = ring_pitch[sel];
      okx = (gx <= longint'(RATE_LIMIT)) && (gx >= -longint'(RATE_LIMIT));
      oky = (gy <= longint'(RATE_LIMIT)) && (gy >= -longint'(RATE_LIMIT));
      rx  = sat32(rx - rnd_shift(gx * longint'(DEG2RAD_Q16), 16));
      ry  = sat32(ry - rnd_shift(gy * longint'(DEG2RAD_Q16), 16));
      if (okx) held_x = rx;
      if (oky) held_y = ry;
      held_raw_x = fx;
      held_raw_y = fy;
      held_okx   = okx;
      held_oky   = oky;
      last_stamp = w.stamp_us;
      o.new_data = 1'b1;
    end
    o.comp_x      = held_x[31:0];
    o.comp_y      = held_y[31:0];
    o.ok_x        = held_okx;
    o.ok_y        = held_oky;
    o.last_raw_x  = held_raw_x[31:0];
    o.last_raw_y  = held_raw_y[31:0];
    o.quality_out = w.link_quality;
    return o;
  endfunction

  task automatic report(string field, longint e, longint a);
    fails++;
    $error("%s: expected %0d, got %0d", field, e, a);
  endtask

  task automatic check_word(out_word_t e, out_word_t a);
    if (a.new_data !== e.new_data)       report("new_data", e.new_data, a.new_data);
    if (a.comp_x !== e.comp_x)           report("comp_x", e.comp_x, a.comp_x);
    if (a.comp_y !== e.comp_y)           report("comp_y", e.comp_y, a.comp_y);
    if (a.ok_x !== e.ok_x)               report("ok_x", e.ok_x, a.ok_x);
    if (a.ok_y !== e.ok_y)               report("ok_y", e.ok_y, a.ok_y);
    if (a.last_raw_x !== e.last_raw_x)   report("last_raw_x", e.last_raw_x, a.last_raw_x);
    if (a.last_raw_y !== e.last_raw_y)   report("last_raw_y", e.last_raw_y, a.last_raw_y);
    if (a.quality_out !== e.quality_out) report("quality_out", e.quality_out, a.quality_out);
  endtask

  // receiver stalls at random outside the calm stretch
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 28);
  end

  // output word monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (comp_words_q.size() == 0) begin
        fails++;
        $error("output word with none expected");
      end else begin
        check_word(comp_words_q.pop_front(), out_word_o);
      end
    end
  end

  // offer one word with random gaps, record its result once taken
  task automatic send_word(in_word_t w, logic typed, out_word_t typed_exp);
    out_word_t e;
    @(negedge clk_i);
    while (!calm && ($urandom_range(99) < 28)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    e = compensated_word(w);
    comp_words_q.push_back(typed ? typed_exp : e);
  endtask

  // stop sending, wait until every pending word has been checked, then let the block settle
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (comp_words_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_COS_ROT:  cfg_cos   = longint'($signed(val[15:0]));
      REG_SIN_ROT:  cfg_sin   = longint'($signed(val[15:0]));
      REG_FLIP_X:   cfg_flip  = val[0];
      REG_GYRO_DLY: cfg_delay = longint'(val[19:0]);
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int          ph, k, n, r;
    in_word_t    w;
    logic [15:0] c_v, s_v;
    logic        f_v;
    logic [19:0] dl_v;
    logic [31:0] tx_stamp;

    // model state after reset
    last_stamp = '0;
    held_x     = 0;
    held_y     = 0;
    held_raw_x = 0;
    held_raw_y = 0;
    held_okx   = 1'b1;
    held_oky   = 1'b1;
    ring_pos   = 0;
    for (k = 0; k < RING_DEPTH; k++) begin
      ring_roll[k]  = 0;
      ring_pitch[k] = 0;
      ring_stamp[k] = '0;
      ring_full[k]  = 1'b0;
    end
    tx_stamp = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table under reset settings
    for (k = 0; k < DIR_N; k++) begin
      send_word(DIR_ROWS[k].w, DIR_ROWS[k].typed, DIR_ROWS[k].exp);
      tx_stamp = DIR_ROWS[k].w.stamp_us;
    end

    // random phases; phase 0 keeps the reset settings, each later phase writes its setting first
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        case (ph)
          1: begin c_v = 16'hC000; s_v = 16'h4000; f_v = 1'b1; dl_v = 20'hF_FFFF; end
          2: begin c_v = 16'h7FFF; s_v = 16'h8000; f_v = 1'b0; dl_v = 20'd4000; end
          3: begin c_v = 16'h2000; s_v = 16'hE000; f_v = 1'b1; dl_v = 20'd2500; end
          4: begin c_v = 16'd11585; s_v = 16'd11585; f_v = 1'b0; dl_v = 20'd0; end
          5: begin
            c_v  = 16'(int'($urandom_range(32768)) - 16384);
            s_v  = 16'(int'($urandom_range(32768)) - 16384);
            f_v  = 1'($urandom());
            dl_v = 20'($urandom_range(20000));
          end
          6: begin
            c_v  = 16'h8000;
            s_v  = 16'h7FFF;
            f_v  = 1'b1;
            dl_v = 20'($urandom_range(20'hF_FFFF));
          end
          default: begin c_v = 16'd16384; s_v = 16'd0; f_v = 1'b0; dl_v = 20'd0; end
        endcase
        settle();
        apb_write(REG_COS_ROT, {16'h0, c_v});
        apb_write(REG_SIN_ROT, {16'h0, s_v});
        apb_write(REG_FLIP_X, {31'h0, f_v});
        apb_write(REG_GYRO_DLY, {12'h0, dl_v});
      end
      // one phase runs with no idling on either side
      calm = (ph == 4);
      for (n = 0; n < PHASE_WORDS; n++) begin
        // mostly rising stamps, some repeats, jumps and wraps
        r = $urandom_range(99);
        if (r < 10)      w.stamp_us = tx_stamp;
        else if (r < 14) w.stamp_us = $urandom();
        else if (r < 17) w.stamp_us = 32'hFFFF_FFFF - $urandom_range(5000);
        else             w.stamp_us = tx_stamp + $urandom_range(3000, 1);
        tx_stamp = w.stamp_us;
        if ($urandom_range(1)) w.flow_x = $urandom();
        else                   w.flow_x = int'($urandom_range(2097152)) - 1048576;
        if ($urandom_range(1)) w.flow_y = $urandom();
        else                   w.flow_y = int'($urandom_range(2097152)) - 1048576;
        if ($urandom_range(99) < 80) w.gyro_roll = 16'(int'($urandom_range(6800)) - 3400);
        else                         w.gyro_roll = 16'($urandom());
        if ($urandom_range(99) < 80) w.gyro_y_rate = 16'(int'($urandom_range(6800)) - 3400);
        else                         w.gyro_y_rate = 16'($urandom());
        w.link_quality = 8'($urandom());
        send_word(w, 1'b0, NO_EXP);
      end
    end
    calm = 1'b0;

    settle();
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
